@@ rtl/bsu_pkg.sv @@
package bsu_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PRINT_ALL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ADD       = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

    typedef enum logic
    {
        ST_IDLE,
        ST_PRINT
    } state_t;

    // Movement applied to every cell in the same cycle; at most one is set.
    typedef struct packed
    {
        logic push;
        logic pop;
        logic add;
        logic rotate;
    } cell_ctrl_t;

endpackage

@@ rtl/bsu_cell.sv @@
module bsu_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic                           clk,
    input  bsu_pkg::cell_ctrl_t            ctrl,
    input  logic                           tail,
    input  logic [bsu_pkg::DATA_W-1:0]     left_value,
    input  logic [bsu_pkg::DATA_W-1:0]     right_value,
    input  logic [bsu_pkg::DATA_W-1:0]     head_value,
    output logic [bsu_pkg::DATA_W-1:0]     value
);

    logic [bsu_pkg::DATA_W-1:0] value_reg;
    logic [bsu_pkg::DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.push)
        begin
            value_next = left_value;
        end
        else if (ctrl.pop)
        begin
            value_next = right_value;
        end
        else if (ctrl.add)
        begin
            // The head takes the wrapped sum of the top two entries; the rest move up.
            value_next = IS_HEAD ? (value_reg + right_value) : right_value;
        end
        else if (ctrl.rotate)
        begin
            // The deepest valid cell closes the ring by taking the head's value.
            value_next = tail ? head_value : right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

@@ rtl/bytecode_stack_unit.sv @@
// Channel  | Direction | Payload
// s_axis   | in        | tdata: push_value[31:0]; tuser: cmd[2:0]
// m_axis   | out       | tdata: out_value[31:0]; tuser: status[1:0]; tlast: last
//
// Push, pop, peek and add: one item per cycle while m_axis keeps up.
// Print all of n entries rotates the ring once per entry and holds s_axis_tready low
// until the bottom entry is loaded into the output register.
// While that register holds an item m_axis has not taken, s_axis_tready stays low.
// rst_n clears the entry count, the state and the output valid; cell data has no reset.
module bytecode_stack_unit #(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic signed [bsu_pkg::DATA_W-1:0]     s_axis_tdata,  // push_value[31:0]
    input  logic [bsu_pkg::CMD_W-1:0]             s_axis_tuser,  // cmd[2:0]
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic signed [bsu_pkg::DATA_W-1:0]     m_axis_tdata,  // out_value[31:0]
    output logic [bsu_pkg::STATUS_W-1:0]          m_axis_tuser,  // status[1:0]
    output logic                                  m_axis_tlast
);

    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);

    bsu_pkg::state_t            state_reg;
    bsu_pkg::state_t            state_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [CNT_W-1:0]           remain_reg;
    logic [CNT_W-1:0]           remain_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [bsu_pkg::DATA_W-1:0] out_value_reg;
    logic [bsu_pkg::DATA_W-1:0] out_value_next;
    logic [bsu_pkg::STATUS_W-1:0] out_status_reg;
    logic [bsu_pkg::STATUS_W-1:0] out_status_next;
    logic                       out_last_reg;
    logic                       out_last_next;

    logic                       can_emit;
    logic                       in_accept;
    logic                       is_empty;
    logic                       is_full;
    logic                       has_two;
    bsu_pkg::cell_ctrl_t        ctrl;

    logic [bsu_pkg::DATA_W-1:0] cell_value [STACK_DEPTH];
    logic [bsu_pkg::DATA_W-1:0] left_in    [STACK_DEPTH];
    logic [bsu_pkg::DATA_W-1:0] right_in   [STACK_DEPTH];

    assign can_emit  = !out_valid_reg || m_axis_tready;
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == FULL_COUNT);
    assign has_two   = (count_reg > CNT_W'(1));

    // Cell 0 is the top of the stack; higher cells lie deeper.
    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_left_head
                assign left_in[gi] = s_axis_tdata;
            end
            else
            begin : g_left_chain
                assign left_in[gi] = cell_value[gi-1];
            end

            if (gi == STACK_DEPTH - 1)
            begin : g_right_end
                assign right_in[gi] = '0;
            end
            else
            begin : g_right_chain
                assign right_in[gi] = cell_value[gi+1];
            end

            bsu_cell #(
                .IS_HEAD (gi == 0)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .tail        (count_reg == CNT_W'(gi + 1)),
                .left_value  (left_in[gi]),
                .right_value (right_in[gi]),
                .head_value  (cell_value[0]),
                .value       (cell_value[gi])
            );
        end
    endgenerate

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsu_pkg::ST_IDLE:
            begin
                if (in_accept && s_axis_tuser == bsu_pkg::CMD_PRINT_ALL && !is_empty)
                begin
                    state_next = bsu_pkg::ST_PRINT;
                end
            end
            bsu_pkg::ST_PRINT:
            begin
                if (can_emit && remain_reg == CNT_W'(1))
                begin
                    state_next = bsu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bsu_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs, cell control and counters.
    always_comb
    begin
        s_axis_tready   = 1'b0;
        ctrl            = '0;
        count_next      = count_reg;
        remain_next     = remain_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            bsu_pkg::ST_IDLE:
            begin
                s_axis_tready = can_emit;
                if (in_accept)
                begin
                    case (s_axis_tuser)
                        bsu_pkg::CMD_PUSH:
                        begin
                            if (is_full)
                            begin
                                out_valid_next  = 1'b1;
                                out_value_next  = '0;
                                out_status_next = bsu_pkg::STATUS_FULL;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                ctrl.push  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        bsu_pkg::CMD_PRINT_ALL:
                        begin
                            remain_next = count_reg;
                        end
                        bsu_pkg::CMD_PEEK:
                        begin
                            out_valid_next  = 1'b1;
                            out_value_next  = is_empty ? '0 : cell_value[0];
                            out_status_next = is_empty ? bsu_pkg::STATUS_EMPTY
                                                       : bsu_pkg::STATUS_OK;
                            out_last_next   = 1'b1;
                        end
                        bsu_pkg::CMD_POP:
                        begin
                            if (is_empty)
                            begin
                                out_valid_next  = 1'b1;
                                out_value_next  = '0;
                                out_status_next = bsu_pkg::STATUS_EMPTY;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                ctrl.pop   = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        bsu_pkg::CMD_ADD:
                        begin
                            if (!has_two)
                            begin
                                out_valid_next  = 1'b1;
                                out_value_next  = '0;
                                out_status_next = bsu_pkg::STATUS_SHORT;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                ctrl.add   = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            ctrl = '0;
                        end
                    endcase
                end
            end
            bsu_pkg::ST_PRINT:
            begin
                if (can_emit)
                begin
                    // After as many rotations as entries, the ring is back in order.
                    ctrl.rotate     = 1'b1;
                    remain_next     = remain_reg - CNT_W'(1);
                    out_valid_next  = 1'b1;
                    out_value_next  = cell_value[0];
                    out_status_next = bsu_pkg::STATUS_OK;
                    out_last_next   = (remain_reg == CNT_W'(1));
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsu_pkg::ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count exceeds the stack depth");

    a_print_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bsu_pkg::ST_PRINT |-> !s_axis_tready && remain_reg != '0)
        else $error("input taken or nothing left while printing");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s_axis_tuser == bsu_pkg::CMD_PUSH && !is_full
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not grow the stack");

    a_print_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bsu_pkg::ST_PRINT |=> count_reg == $past(count_reg))
        else $error("entry count changed during print all");
`endif

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH = 64;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned HOLD_AFTER = 60;

    // Encodings the block does not define; it must drop them silently.
    localparam logic [bsu_pkg::CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [bsu_pkg::CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [bsu_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;

    typedef struct packed
    {
        logic [bsu_pkg::DATA_W-1:0]   value;
        logic [bsu_pkg::STATUS_W-1:0] status;
        logic                         last;
    } stack_result_t;

    typedef struct
    {
        logic [bsu_pkg::CMD_W-1:0]  op;
        logic [bsu_pkg::DATA_W-1:0] arg;
        int unsigned                gap;
        bit                         drain;
    } instr_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic signed [bsu_pkg::DATA_W-1:0]  s_data = '0;
    logic [bsu_pkg::CMD_W-1:0]          s_user = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic signed [bsu_pkg::DATA_W-1:0]  m_data;
    logic [bsu_pkg::STATUS_W-1:0]       m_user;
    logic                               m_last;

    bytecode_stack_unit #(
        .STACK_DEPTH (DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last)
    );

    // Predicted stack contents, index 0 is the bottom.
    logic [bsu_pkg::DATA_W-1:0] shadow_stack [DEPTH];
    int unsigned                shadow_count = 0;

    stack_result_t     pending_results [$];
    instr_item_t       instr_queue [$];

    int unsigned gen_count = 0;
    int unsigned items_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic expect_result(input logic [bsu_pkg::DATA_W-1:0] value,
                                 input logic [bsu_pkg::STATUS_W-1:0] status,
                                 input logic last);
        stack_result_t r;
        r.value = value;
        r.status = status;
        r.last = last;
        pending_results.push_back(r);
    endtask

    task automatic predict_instr(input logic [bsu_pkg::CMD_W-1:0] op,
                                 input logic [bsu_pkg::DATA_W-1:0] arg);
        case (op)
            bsu_pkg::CMD_PUSH:
                if (shadow_count >= DEPTH)
                    expect_result('0, bsu_pkg::STATUS_FULL, 1'b1);
                else
                begin
                    shadow_stack[shadow_count] = arg;
                    shadow_count++;
                end
            bsu_pkg::CMD_PRINT_ALL:
                for (int i = shadow_count; i > 0; i--)
                    expect_result(shadow_stack[i-1], bsu_pkg::STATUS_OK, i == 1);
            bsu_pkg::CMD_PEEK:
                if (shadow_count == 0)
                    expect_result('0, bsu_pkg::STATUS_EMPTY, 1'b1);
                else
                    expect_result(shadow_stack[shadow_count-1], bsu_pkg::STATUS_OK, 1'b1);
            bsu_pkg::CMD_POP:
                if (shadow_count == 0)
                    expect_result('0, bsu_pkg::STATUS_EMPTY, 1'b1);
                else
                    shadow_count--;
            bsu_pkg::CMD_ADD:
                if (shadow_count < 2)
                    expect_result('0, bsu_pkg::STATUS_SHORT, 1'b1);
                else
                begin
                    shadow_stack[shadow_count-2] = shadow_stack[shadow_count-2]
                                                 + shadow_stack[shadow_count-1];
                    shadow_count--;
                end
            default:
                ;
        endcase
    endtask

    // The generator keeps a rough depth so that it can steer the mix.
    task automatic add_instr(input logic [bsu_pkg::CMD_W-1:0] op,
                             input logic [bsu_pkg::DATA_W-1:0] arg,
                             input int unsigned gap);
        instr_item_t it;
        it.op = op;
        it.arg = arg;
        it.gap = gap;
        it.drain = 1'b0;
        instr_queue.push_back(it);
        case (op)
            bsu_pkg::CMD_PUSH:
                if (gen_count < DEPTH)
                    gen_count++;
            bsu_pkg::CMD_POP, bsu_pkg::CMD_ADD:
                if (gen_count > (op == bsu_pkg::CMD_ADD ? 1 : 0))
                    gen_count--;
            default:
                ;
        endcase
    endtask

    task automatic add_drain();
        instr_item_t it;
        it.op = bsu_pkg::CMD_PEEK;
        it.arg = '0;
        it.gap = 0;
        it.drain = 1'b1;
        instr_queue.push_back(it);
    endtask

    function automatic logic [bsu_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned pick_gap(input int unsigned max_gap);
        return $urandom_range(0, max_gap);
    endfunction

    task automatic add_random_instr(input int unsigned max_gap);
        int unsigned r;
        int unsigned rsvd;
        r = $urandom_range(0, 99);
        // Lean toward pushes on a shallow stack so that the deeper states are reached.
        if (gen_count < 4 && r >= 40 && r < 70)
            r = 0;
        if (r < 40)
            add_instr(bsu_pkg::CMD_PUSH, pick_value(), pick_gap(max_gap));
        else if (r < 54)
            add_instr(bsu_pkg::CMD_POP, $urandom, pick_gap(max_gap));
        else if (r < 68)
            add_instr(bsu_pkg::CMD_PEEK, $urandom, pick_gap(max_gap));
        else if (r < 84)
            add_instr(bsu_pkg::CMD_ADD, $urandom, pick_gap(max_gap));
        else if (r < 93)
            add_instr(bsu_pkg::CMD_PRINT_ALL, $urandom, pick_gap(max_gap));
        else
        begin
            rsvd = $urandom_range(32'(CMD_RSVD5), 32'(CMD_RSVD7));
            add_instr(rsvd[bsu_pkg::CMD_W-1:0], $urandom, pick_gap(max_gap));
        end
    endtask

    // Driver: offers the head of the queue after its idle gap; a drain item waits until no result is pending.
    int unsigned tx_wait = 0;
    logic        tx_next_valid;
    instr_item_t tx_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid <= 1'b0;
            tx_wait = 0;
        end
        else
        begin
            tx_next_valid = s_valid;
            if (s_valid && s_ready)
            begin
                predict_instr(s_user, s_data);
                items_accepted++;
                tx_next_valid = 1'b0;
            end
            if (!tx_next_valid && instr_queue.size() > 0)
            begin
                if (instr_queue[0].drain)
                begin
                    if (pending_results.size() == 0)
                        void'(instr_queue.pop_front());
                end
                else if (tx_wait < instr_queue[0].gap)
                    tx_wait++;
                else
                begin
                    tx_item = instr_queue.pop_front();
                    tx_wait = 0;
                    tx_next_valid = 1'b1;
                    s_data <= tx_item.arg;
                    s_user <= tx_item.op;
                end
            end
            s_valid <= tx_next_valid;
        end
    end

    // Monitor: checks each result and draws the stall before the next one.
    logic          rx_hold = 1'b0;
    int unsigned   rx_wait = 0;
    logic          rx_next_ready;
    stack_result_t rx_want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (m_valid && m_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value %h status %0d last %0b",
                                 m_data, m_user, m_last);
                end
                else
                begin
                    rx_want = pending_results.pop_front();
                    if (m_data !== rx_want.value || m_user !== rx_want.status
                        || m_last !== rx_want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected value %h status %0d last %0b, %s",
                                     results_seen, rx_want.value, rx_want.status,
                                     rx_want.last, $sformatf("got value %h status %0d last %0b",
                                     m_data, m_user, m_last));
                    end
                end
                results_seen++;
                // Every third stretch of forty results runs without stalls.
                rx_wait = ((results_seen / 40) % 3 == 0) ? 0 : $urandom_range(0, 14);
            end
            if (rx_hold)
                rx_next_ready = 1'b0;
            else if (rx_wait > 0)
            begin
                rx_wait--;
                rx_next_ready = 1'b0;
            end
            else
                rx_next_ready = 1'b1;
            m_ready <= rx_next_ready;
        end
    end

    // Long receiver stall so that the output register fills and the input backs up.
    initial
    begin
        wait (items_accepted >= HOLD_AFTER);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        // Errors on an empty stack, then sums that wrap around.
        add_instr(bsu_pkg::CMD_PEEK, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_POP, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_ADD, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_PRINT_ALL, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_PUSH, 32'h8000_0000, pick_gap(14));
        add_instr(bsu_pkg::CMD_ADD, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_PEEK, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_PUSH, 32'h7FFF_FFFF, pick_gap(14));
        add_instr(bsu_pkg::CMD_PRINT_ALL, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_ADD, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_PEEK, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_PUSH, 32'h0000_0001, pick_gap(14));
        add_instr(bsu_pkg::CMD_ADD, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_PEEK, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_PUSH, 32'hFFFF_FFFF, pick_gap(14));
        add_instr(bsu_pkg::CMD_PUSH, 32'h7FFF_FFFF, pick_gap(14));
        add_instr(bsu_pkg::CMD_ADD, $urandom, pick_gap(14));
        add_instr(CMD_RSVD5, $urandom, pick_gap(14));
        add_instr(CMD_RSVD6, 32'hFFFF_FFFF, pick_gap(14));
        add_instr(CMD_RSVD7, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_PRINT_ALL, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_POP, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_POP, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_POP, $urandom, pick_gap(14));
        add_drain();

        for (int i = 0; i < 100; i++)
            add_random_instr(14);
        add_drain();

        // Fill to the top without gaps, overflow it, and read the whole stack back.
        while (gen_count < DEPTH)
            add_instr(bsu_pkg::CMD_PUSH, pick_value(), 0);
        add_instr(bsu_pkg::CMD_PUSH, $urandom, 0);
        add_instr(bsu_pkg::CMD_PUSH, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_PEEK, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_PRINT_ALL, $urandom, pick_gap(14));
        for (int i = 0; i < 4; i++)
            add_instr(bsu_pkg::CMD_ADD, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_POP, $urandom, pick_gap(14));
        add_instr(bsu_pkg::CMD_PRINT_ALL, $urandom, 0);

        for (int i = 0; i < 110; i++)
            add_random_instr((i / 30) % 2 == 0 ? 14 : 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (instr_queue.size() != 0 || s_valid);
        do
            @(negedge clk);
        while (pending_results.size() != 0);
        repeat (16) @(posedge clk);

        if (pending_results.size() != 0)
            mismatches += pending_results.size();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
